[hdl/hcb_pkg.sv]
// Package for the byte Huffman coder: widths, constants and shared types.
// No dependencies.
package hcb_pkg;
	localparam int AlphabetSize   = 256;
	localparam int MaxMessageLen  = 65536;
	localparam int MaxCodeLen     = 24;
	localparam int SymW           = 8;
	localparam int CntW           = 17;
	localparam int CodeW          = 24;
	localparam int LenW           = 5;
	localparam logic [CntW-1:0] WeightMax = '1;

	typedef struct packed {
		logic            mode;
		logic [SymW-1:0] symbol;
	} cmd_t;

	typedef struct packed {
		logic [CodeW-1:0] code_bits;
		logic [LenW-1:0]  code_length;
	} res_t;
endpackage

[hdl/hcb_front.sv]
// Front end: accepts input beats and queues them as commands.
// Depends on hcb_pkg.
module hcb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	input  hcb_pkg::cmd_t s_cmd,
	output logic          q_valid,
	input  logic          q_ready,
	output hcb_pkg::cmd_t q_cmd
);
	import hcb_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign s_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) mem_q[wp_q] <= s_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (s_valid && s_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(s_valid && s_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

[hdl/hcb_back.sv]
// Back end: histogram, tree build sequencer, code tables and result register.
// Depends on hcb_pkg.
module hcb_back #(
	parameter int ALPHABET_SIZE      = hcb_pkg::AlphabetSize,
	parameter int MAX_MESSAGE_LENGTH = hcb_pkg::MaxMessageLen,
	parameter int MAX_CODE_LENGTH    = hcb_pkg::MaxCodeLen
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  hcb_pkg::cmd_t q_cmd,
	output logic          m_valid,
	input  logic          m_ready,
	output hcb_pkg::res_t m_res
);
	import hcb_pkg::*;

	localparam int NodeN = 2 * ALPHABET_SIZE - 1;
	localparam int NW    = $clog2(NodeN);
	localparam int AW    = $clog2(ALPHABET_SIZE);

	typedef enum logic [3:0] {
		ST_RUN, ST_CNT, ST_CLR, ST_LEAF, ST_MIN_RD, ST_MIN, ST_MERGE, ST_ROOT,
		ST_WALK, ST_WALK2, ST_EMIT, ST_TBL, ST_EMIT2, ST_LOOK
	} st_t;

	st_t st_q;

	logic [CntW-1:0]  cnt_mem  [ALPHABET_SIZE];
	logic [CntW-1:0]  w_mem    [NodeN];
	logic [NW-1:0]    c0_mem   [NodeN];
	logic [NW-1:0]    c1_mem   [NodeN];
	logic [SymW-1:0]  lsym_mem [ALPHABET_SIZE];
	logic [CodeW-1:0] pc_mem   [NodeN];
	logic [LenW-1:0]  pl_mem   [NodeN];
	logic [CodeW-1:0] code_mem [ALPHABET_SIZE];
	logic [LenW-1:0]  len_mem  [ALPHABET_SIZE];
	logic [NodeN-1:0] live_q;
	logic [ALPHABET_SIZE-1:0] cnz_q, tv_q;

	logic            built_q;
	logic [SymW:0]   idx_q;
	logic [NW:0]     total_q, leaves_q, n_q, scan_q, best_q;
	logic            found_q, second_q;
	logic [CntW-1:0] bw_q, wa_q, rd_w_q;
	logic [NW-1:0]   a_q;
	logic            rd_live_q;
	logic [NW:0]     rd_idx_q;
	logic [CntW-1:0] cnt_rd_q;
	logic [SymW-1:0] sym_q;
	logic [CodeW-1:0] pc_q;
	logic [LenW-1:0]  pl_q;
	logic [NW-1:0]    ch0_q, ch1_q;
	logic [CntW:0]    sum;
	logic             in_rng;
	logic [AW-1:0]    cnt_ra;
	logic [NW-1:0]    pc_ra;

	assign in_rng  = {1'b0, q_cmd.symbol} < (SymW+1)'(ALPHABET_SIZE);
	assign q_ready = st_q == ST_RUN && !m_valid && !(q_cmd.mode && !built_q);
	assign sum     = {1'b0, wa_q} + {1'b0, bw_q};
	assign cnt_ra  = (st_q == ST_RUN) ? q_cmd.symbol[AW-1:0] :
		(st_q == ST_LEAF) ? idx_q[AW-1:0] + 1'b1 : '0;
	assign pc_ra   = (st_q == ST_EMIT2) ? n_q[NW-1:0] + 1'b1 : n_q[NW-1:0];

	always_ff @(posedge clk) begin
		cnt_rd_q <= cnt_mem[cnt_ra];
		rd_w_q   <= w_mem[scan_q[NW-1:0]];
		rd_live_q <= live_q[scan_q[NW-1:0]];
		rd_idx_q <= scan_q;
		pc_q  <= pc_mem[pc_ra];
		pl_q  <= pl_mem[pc_ra];
		ch0_q <= c0_mem[n_q[NW-1:0]];
		ch1_q <= c1_mem[n_q[NW-1:0]];
		if (st_q == ST_CNT)
			cnt_mem[sym_q[AW-1:0]] <= cnz_q[sym_q[AW-1:0]] ?
				cnt_rd_q + CntW'(cnt_rd_q < CntW'(MAX_MESSAGE_LENGTH)) : CntW'(1);
		if (st_q == ST_LEAF && cnz_q[idx_q[AW-1:0]]) begin
			w_mem[total_q[NW-1:0]] <= cnt_rd_q;
			lsym_mem[total_q[AW-1:0]] <= idx_q[SymW-1:0];
		end
		if (st_q == ST_MERGE) begin
			w_mem[total_q[NW-1:0]] <= sum[CntW] ? WeightMax : sum[CntW-1:0];
			c0_mem[total_q[NW-1:0]] <= a_q;
			c1_mem[total_q[NW-1:0]] <= best_q[NW-1:0];
		end
		if (st_q == ST_ROOT) begin
			pc_mem[total_q[NW-1:0] - 1'b1] <= '0;
			pl_mem[total_q[NW-1:0] - 1'b1] <= '0;
		end
		if (st_q == ST_WALK2) begin
			pc_mem[ch0_q] <= (32'(pl_q) < MAX_CODE_LENGTH) ? {pc_q[CodeW-2:0], 1'b0} : pc_q;
			pl_mem[ch0_q] <= (32'(pl_q) < MAX_CODE_LENGTH) ? pl_q + 1'b1 : pl_q;
		end
		if (st_q == ST_EMIT) begin
			pc_mem[ch1_q] <= (32'(pl_q) < MAX_CODE_LENGTH) ? {pc_q[CodeW-2:0], 1'b1} : pc_q;
			pl_mem[ch1_q] <= (32'(pl_q) < MAX_CODE_LENGTH) ? pl_q + 1'b1 : pl_q;
		end
		if (st_q == ST_EMIT2) begin
			code_mem[sym_q[AW-1:0]] <= pc_q;
			len_mem[sym_q[AW-1:0]]  <= pl_q;
		end
		if (st_q == ST_LOOK)
			m_res <= (sym_q < SymW'(ALPHABET_SIZE - 1) || 32'(sym_q) == ALPHABET_SIZE - 1)
				&& tv_q[sym_q[AW-1:0]] ? {code_mem[sym_q[AW-1:0]], len_mem[sym_q[AW-1:0]]}
				: '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN; built_q <= 1'b0; m_valid <= 1'b0;
			cnz_q <= '0; tv_q <= '0; live_q <= '0;
			idx_q <= '0; total_q <= '0; leaves_q <= '0; n_q <= '0;
			scan_q <= '0; best_q <= '0; found_q <= 1'b0; second_q <= 1'b0;
			bw_q <= '0; wa_q <= '0; a_q <= '0; sym_q <= '0;
		end else begin
			if (m_valid && m_ready) m_valid <= 1'b0;
			case (st_q)
			ST_RUN: begin
				if (q_valid && !m_valid) begin
					if (!q_cmd.mode) begin
						if (in_rng) begin
							sym_q <= q_cmd.symbol; st_q <= ST_CNT;
						end
					end else if (!built_q) begin
						st_q <= ST_CLR; tv_q <= '0; live_q <= '0;
					end else begin
						sym_q <= q_cmd.symbol; st_q <= ST_LOOK;
					end
				end
			end
			ST_CNT: begin
				cnz_q[sym_q[AW-1:0]] <= 1'b1;
				built_q <= 1'b0;
				st_q <= ST_RUN;
			end
			ST_CLR: begin
				idx_q <= '0; total_q <= '0; st_q <= ST_LEAF;
			end
			ST_LEAF: begin
				if (cnz_q[idx_q[AW-1:0]]) begin
					live_q[total_q[NW-1:0]] <= 1'b1;
					total_q <= total_q + 1'b1;
				end
				if (32'(idx_q) == ALPHABET_SIZE - 1) begin
					leaves_q <= total_q + (NW+1)'(cnz_q[idx_q[AW-1:0]]);
					if (total_q + (NW+1)'(cnz_q[idx_q[AW-1:0]]) <= (NW+1)'(1)) begin
						built_q <= 1'b1; st_q <= ST_RUN;
					end else begin
						scan_q <= '0; found_q <= 1'b0; second_q <= 1'b0;
						st_q <= ST_MIN_RD;
					end
				end
				idx_q <= idx_q + 1'b1;
			end
			ST_MIN_RD: begin
				scan_q <= scan_q + 1'b1; st_q <= ST_MIN;
			end
			ST_MIN: begin
				if (rd_live_q && (!found_q || rd_w_q < bw_q)) begin
					best_q <= rd_idx_q; bw_q <= rd_w_q; found_q <= 1'b1;
				end
				if (rd_idx_q == total_q - 1'b1) begin
					st_q <= ST_MERGE;
				end else scan_q <= scan_q + 1'b1;
			end
			ST_MERGE: begin
				live_q[best_q[NW-1:0]] <= 1'b0;
				scan_q <= '0; found_q <= 1'b0;
				if (!second_q) begin
					a_q <= best_q[NW-1:0]; wa_q <= bw_q; second_q <= 1'b1;
					st_q <= ST_MIN_RD;
				end else begin
					live_q[total_q[NW-1:0]] <= 1'b1;
					total_q <= total_q + 1'b1;
					second_q <= 1'b0;
					if (total_q + 1'b1 == (leaves_q << 1) - 1'b1) st_q <= ST_ROOT;
					else st_q <= ST_MIN_RD;
				end
			end
			ST_ROOT: begin
				n_q <= total_q - 1'b1; st_q <= ST_WALK;
			end
			ST_WALK: st_q <= ST_WALK2;
			ST_WALK2: st_q <= ST_EMIT;
			ST_EMIT: begin
				if (n_q == leaves_q) begin
					n_q <= '0; st_q <= ST_TBL;
				end else begin
					n_q <= n_q - 1'b1; st_q <= ST_WALK;
				end
			end
			ST_TBL: st_q <= ST_EMIT2;
			ST_EMIT2: begin
				tv_q[sym_q[AW-1:0]] <= 1'b1;
				if (n_q + 1'b1 == leaves_q) begin
					built_q <= 1'b1; st_q <= ST_RUN;
				end else n_q <= n_q + 1'b1;
			end
			ST_LOOK: begin
				m_valid <= 1'b1; st_q <= ST_RUN;
			end
			default: st_q <= ST_RUN;
			endcase
			if (st_q == ST_EMIT2 || (st_q == ST_EMIT && n_q == leaves_q))
				sym_q <= lsym_mem[(st_q == ST_EMIT2 ? n_q[AW-1:0] + 1'b1 : '0)];
		end
	end
endmodule

[hdl/huffman_code_builder_encoder.sv]
// Top level of the byte Huffman coder: input queue front end and coding back end.
// Depends on hcb_pkg, hcb_front, hcb_back.
// Count beats (mode 0) occupy the back end and give no result; encode beats (mode 1)
// give one result, registered in the lookup state after the beat is accepted. The back
// end takes no new beat while a result waits for the receiver. The first encode beat
// after any count beat triggers a tree build by linear minimum search over the node
// weight memory; the two-entry input queue fills and stalls the input meanwhile.
module huffman_code_builder_encoder #(
	parameter int ALPHABET_SIZE      = hcb_pkg::AlphabetSize,
	parameter int MAX_MESSAGE_LENGTH = hcb_pkg::MaxMessageLen,
	parameter int MAX_CODE_LENGTH    = hcb_pkg::MaxCodeLen
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // symbol
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // code_bits, code_length, zero pad
);
	import hcb_pkg::*;

	cmd_t s_cmd, q_cmd;
	res_t res;
	logic q_valid, q_ready;

	assign s_cmd = '{s_axis_tuser, s_axis_tdata};
	assign m_axis_tdata = {3'b0, res.code_length, res.code_bits};

	hcb_front u_front (
		.clk, .arst_n, .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	hcb_back #(
		.ALPHABET_SIZE(ALPHABET_SIZE), .MAX_MESSAGE_LENGTH(MAX_MESSAGE_LENGTH),
		.MAX_CODE_LENGTH(MAX_CODE_LENGTH)
	) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_res(res)
	);

`ifndef SYNTHESIS
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[28:24] <= 5'(MAX_CODE_LENGTH))
		else $error("code length too large");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:29] == 3'b0)
		else $error("pad bits set");
`endif
endmodule
